@@ rtl/core/positional_list_engine_assert.svh @@
// assertion macros used by the back part of the list engine rtl
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/plst_pkg.sv @@
// shared types, codes and constants of the list engine
package plst_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int POS_W           = 6;
  localparam int ACT_W           = 3;
  localparam int STAT_W          = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FWD    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_REV    = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_COUNT,
    OP_FWD,
    OP_REV
  } op_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] value_res;
    logic [POS_W-1:0]         position_res;
    logic [POS_W-1:0]         count;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    op_t                      op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } cmd_t;

endpackage

@@ rtl/core/plst_ram.sv @@
// generic single-port-write ram with registered read
module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/plst_queue.sv @@
// short command queue between the front and back parts
module plst_queue
  import plst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + QCW'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full  = (fill_r == QCW'(QUEUE_DEPTH));
  assign avail = (fill_r != '0);
  assign head  = slot_r[rd_ptr_r];

endmodule

@@ rtl/core/plst_front.sv @@
// input side: takes transfers, decodes the action and queues commands
module plst_front
  import plst_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic known;
  op_t  op;

  always_comb begin
    known = 1'b1;
    op    = OP_COUNT;
    unique case (in_data.action)
      ACT_INSERT: op = OP_INSERT;
      ACT_DELETE: op = OP_DELETE;
      ACT_SEARCH: op = OP_SEARCH;
      ACT_COUNT:  op = OP_COUNT;
      ACT_FWD:    op = OP_FWD;
      ACT_REV:    op = OP_REV;
      default:    known = 1'b0;
    endcase
  end

  // unused action codes are taken and dropped
  assign in_stall       = q_full;
  assign q_push         = in_valid && !q_full && known;
  assign q_cmd.op       = op;
  assign q_cmd.value    = in_data.value;
  assign q_cmd.position = in_data.position;

endmodule

@@ rtl/core/plst_back.sv @@
// back part: list storage, shift, scan and stream sequencer, result register
`include "positional_list_engine_assert.svh"

module plst_back
  import plst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_avail,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int AW1  = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_STREAM = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  op_t                      op_r, op_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]            pidx_r, pidx_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            last_r, last_nxt;
  logic [AW-1:0]            ra_r, ra_nxt;
  logic                     up_r, up_nxt;
  logic                     rd_go_r, rd_go_nxt;
  logic                     rv_r, rv_nxt;
  logic signed [DATA_W-1:0] removed_r, removed_nxt;
  out_item_t                res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_r, out_nxt;

  logic              re, we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;

  logic             out_free, consume, rd_state, at_last;
  logic [CMPW-1:0]  pos_c, cnt_c;
  logic [POS_W-1:0] cnt6, ra_pos;

  plst_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign pos_c    = CMPW'(q_head.position);
  assign cnt_c    = CMPW'(count_r);
  assign cnt6     = POS_W'(count_r);
  assign ra_pos   = POS_W'({1'b0, ra_r} + AW1'(1));
  assign at_last  = (ra_r == last_r);
  assign rd_state = (state_r == S_SHIFT) || (state_r == S_SCAN) || (state_r == S_STREAM);
  assign consume  = rv_r && ((state_r != S_STREAM) || out_free);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    pidx_nxt      = pidx_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    ra_nxt        = ra_r;
    up_nxt        = up_r;
    rd_go_nxt     = rd_go_r;
    rv_nxt        = rv_r && !consume;
    removed_nxt   = removed_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    q_pop         = 1'b0;
    re            = 1'b0;
    we            = 1'b0;
    waddr         = pidx_r;
    wdata         = key_r;

    // read issue, one entry a cycle while the read data slot drains
    if (rd_state && rd_go_r && (!rv_r || consume)) begin
      re     = 1'b1;
      rv_nxt = 1'b1;
      ra_nxt = addr_r;
      if (addr_r == last_r) begin
        rd_go_nxt = 1'b0;
      end else begin
        addr_nxt = up_r ? (addr_r + AW'(1)) : (addr_r - AW'(1));
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_avail) begin
          q_pop                = 1'b1;
          op_nxt               = q_head.op;
          key_nxt              = q_head.value;
          pos_nxt              = q_head.position;
          rv_nxt               = 1'b0;
          rd_go_nxt            = 1'b0;
          res_nxt.status       = ST_OK;
          res_nxt.value_res    = q_head.value;
          res_nxt.position_res = q_head.position;
          res_nxt.count        = cnt6;
          res_nxt.last         = 1'b1;
          state_nxt            = S_RESP;
          unique case (q_head.op) inside
            OP_INSERT: begin
              if ((pos_c == '0) || (pos_c > cnt_c + CMPW'(1))) begin
                res_nxt.status = ST_BADPOS;
              end else if (count_r == CW'(MAX_ENTRIES)) begin
                res_nxt.status = ST_FULL;
              end else begin
                state_nxt = S_SHIFT;
                pidx_nxt  = AW'(pos_c - CMPW'(1));
                last_nxt  = AW'(pos_c - CMPW'(1));
                addr_nxt  = AW'(cnt_c - CMPW'(1));
                up_nxt    = 1'b0;
                rd_go_nxt = (pos_c <= cnt_c);
              end
            end
            OP_DELETE: begin
              res_nxt.value_res = '0;
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else if ((pos_c == '0) || (pos_c > cnt_c)) begin
                res_nxt.status = ST_BADPOS;
              end else begin
                state_nxt = S_SHIFT;
                pidx_nxt  = AW'(pos_c - CMPW'(1));
                addr_nxt  = AW'(pos_c - CMPW'(1));
                last_nxt  = AW'(cnt_c - CMPW'(1));
                up_nxt    = 1'b1;
                rd_go_nxt = 1'b1;
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                res_nxt.status       = ST_EMPTY;
                res_nxt.value_res    = '0;
                res_nxt.position_res = '0;
              end else begin
                state_nxt = S_SCAN;
                addr_nxt  = '0;
                last_nxt  = AW'(cnt_c - CMPW'(1));
                up_nxt    = 1'b1;
                rd_go_nxt = 1'b1;
              end
            end
            OP_FWD, OP_REV: begin
              if (count_r == '0) begin
                res_nxt.status       = ST_EMPTY;
                res_nxt.value_res    = '0;
                res_nxt.position_res = '0;
              end else begin
                state_nxt = S_STREAM;
                up_nxt    = (q_head.op == OP_FWD);
                addr_nxt  = (q_head.op == OP_FWD) ? '0 : AW'(cnt_c - CMPW'(1));
                last_nxt  = (q_head.op == OP_FWD) ? AW'(cnt_c - CMPW'(1)) : '0;
                rd_go_nxt = 1'b1;
              end
            end
            default: begin
              res_nxt.value_res    = '0;
              res_nxt.position_res = '0;
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (rv_r) begin
          if (op_r == OP_INSERT) begin
            we    = 1'b1;
            waddr = ra_r + AW'(1);
            wdata = rdata;
          end else if (ra_r == pidx_r) begin
            removed_nxt = rdata;
          end else begin
            we    = 1'b1;
            waddr = ra_r - AW'(1);
            wdata = rdata;
          end
        end
        if (!rd_go_r && !rv_r) begin
          res_nxt.status       = ST_OK;
          res_nxt.position_res = pos_r;
          res_nxt.last         = 1'b1;
          if (op_r == OP_INSERT) begin
            we                = 1'b1;
            waddr             = pidx_r;
            wdata             = key_r;
            count_nxt         = count_r + CW'(1);
            res_nxt.value_res = key_r;
          end else begin
            count_nxt         = count_r - CW'(1);
            res_nxt.value_res = removed_r;
          end
          res_nxt.count = POS_W'(count_nxt);
          state_nxt     = S_RESP;
        end
      end

      S_SCAN: begin
        if (rv_r) begin
          res_nxt.value_res = key_r;
          res_nxt.count     = cnt6;
          res_nxt.last      = 1'b1;
          if (rdata == key_r) begin
            res_nxt.status       = ST_OK;
            res_nxt.position_res = ra_pos;
            state_nxt            = S_RESP;
            rd_go_nxt            = 1'b0;
            rv_nxt               = 1'b0;
          end else if (at_last) begin
            res_nxt.status       = ST_NOTFOUND;
            res_nxt.position_res = '0;
            state_nxt            = S_RESP;
            rd_go_nxt            = 1'b0;
            rv_nxt               = 1'b0;
          end
        end
      end

      S_STREAM: begin
        if (rv_r && out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = ST_OK;
          out_nxt.value_res    = rdata;
          out_nxt.position_res = ra_pos;
          out_nxt.count        = cnt6;
          out_nxt.last         = at_last;
          if (at_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_go_r     <= 1'b0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_go_r     <= rd_go_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    pos_r     <= pos_nxt;
    pidx_r    <= pidx_nxt;
    addr_r    <= addr_nxt;
    last_r    <= last_nxt;
    ra_r      <= ra_nxt;
    up_r      <= up_nxt;
    removed_r <= removed_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PLE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(MAX_ENTRIES), "entry count above capacity")
  `PLE_ASSERT_IMP(a_count_change, count_r != $past(count_r), $past(state_r) == S_SHIFT, "count moved outside a shift")
  `PLE_ASSERT_IMP(a_read_state, rv_r, state_r == S_SHIFT || state_r == S_SCAN || state_r == S_STREAM, "read data pending outside a read phase")
  `PLE_ASSERT_NXT(a_resp_load, state_r == S_RESP && out_free, out_valid_r && state_r == S_IDLE, "response not loaded")

endmodule

@@ rtl/core/positional_list_engine.sv @@
// insert/delete shift the entries from the position on by one place, an append insert shifts none
// search scans from the first entry, answering at the first match or after the last entry
// streams: one result a cycle while the output is not stalled, the last one flagged
// count and empty/error answers go straight to the response; one command at a time, the next
// starts once the last result is loaded; the list ram reads one entry and writes one per cycle
// reset clears the entry count and handshake state; stored entries are not cleared
module positional_list_engine
  import plst_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic q_full, q_push, q_pop, q_avail;
  cmd_t q_cmd, q_head;

  plst_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  plst_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .head     (q_head)
  );

  plst_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the positional list engine: directed table then random traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plst_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  word_t       list_vals[$];
  out_item_t   pending_results[$];
  script_row_t script[$];
  int          n_errors = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;
  bit          filling = 1'b1;

  positional_list_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= 40) begin
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  function automatic out_item_t result_of(logic [STAT_W-1:0] st, word_t v, logic [POS_W-1:0] p,
                                          bit lst);
    out_item_t r;
    r.status       = st;
    r.value_res    = v;
    r.position_res = p;
    r.count        = POS_W'(list_vals.size());
    r.last         = lst;
    return r;
  endfunction

  function automatic void step_list(input in_item_t c, output out_item_t res[$]);
    int    n;
    int    p;
    int    hit;
    int    idx;
    word_t removed;
    res = {};
    n   = list_vals.size();
    p   = int'(c.position);
    case (c.action)
      ACT_INSERT: begin
        if (p < 1 || p > n + 1) begin
          res.push_back(result_of(ST_BADPOS, c.value, c.position, 1'b1));
        end else if (n >= MAX_ENTRIES_DEF) begin
          res.push_back(result_of(ST_FULL, c.value, c.position, 1'b1));
        end else begin
          list_vals.insert(p - 1, c.value);
          res.push_back(result_of(ST_OK, c.value, c.position, 1'b1));
        end
      end
      ACT_DELETE: begin
        if (n == 0) begin
          res.push_back(result_of(ST_EMPTY, '0, c.position, 1'b1));
        end else if (p < 1 || p > n) begin
          res.push_back(result_of(ST_BADPOS, '0, c.position, 1'b1));
        end else begin
          removed = list_vals[p - 1];
          list_vals.delete(p - 1);
          res.push_back(result_of(ST_OK, removed, c.position, 1'b1));
        end
      end
      ACT_SEARCH: begin
        hit = -1;
        foreach (list_vals[i]) begin
          if (hit < 0 && list_vals[i] == c.value) hit = i;
        end
        if (n == 0) res.push_back(result_of(ST_EMPTY, '0, '0, 1'b1));
        else if (hit >= 0) res.push_back(result_of(ST_OK, c.value, POS_W'(hit + 1), 1'b1));
        else res.push_back(result_of(ST_NOTFOUND, c.value, '0, 1'b1));
      end
      ACT_COUNT: res.push_back(result_of(ST_OK, '0, '0, 1'b1));
      ACT_FWD, ACT_REV: begin
        if (n == 0) res.push_back(result_of(ST_EMPTY, '0, '0, 1'b1));
        for (int i = 0; i < n; i++) begin
          idx = (c.action == ACT_FWD) ? i : n - 1 - i;
          res.push_back(result_of(ST_OK, list_vals[idx], POS_W'(idx + 1), i == n - 1));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void plan_typed(logic [ACT_W-1:0] act, word_t v, logic [POS_W-1:0] p,
                                     logic [STAT_W-1:0] st, word_t vr, logic [POS_W-1:0] pr,
                                     logic [POS_W-1:0] cnt);
    script_row_t row;
    row.cmd  = '{action: act, value: v, position: p};
    row.typed = 1'b1;
    row.want = '{status: st, value_res: vr, position_res: pr, count: cnt, last: 1'b1};
    script.push_back(row);
  endfunction

  function automatic void plan_open(logic [ACT_W-1:0] act, word_t v, logic [POS_W-1:0] p);
    script_row_t row;
    row.cmd   = '{action: act, value: v, position: p};
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  task automatic send_command(input in_item_t c, input bit typed, input out_item_t want);
    int        gap;
    out_item_t got[$];
    if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall !== 1'b0);
    step_list(c, got);
    if (typed) pending_results.push_back(want);
    else foreach (got[i]) pending_results.push_back(got[i]);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    in_item_t c;
    int       n;
    int       roll;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    plan_typed(ACT_COUNT,  32'sd0, 6'd0, ST_OK, 32'sd0, 6'd0, 6'd0);
    plan_typed(ACT_DELETE, 32'sd9, 6'd1, ST_EMPTY, 32'sd0, 6'd1, 6'd0);
    plan_typed(ACT_SEARCH, 32'sd42, 6'd0, ST_EMPTY, 32'sd0, 6'd0, 6'd0);
    plan_typed(ACT_FWD,    32'sd0, 6'd0, ST_EMPTY, 32'sd0, 6'd0, 6'd0);
    plan_typed(ACT_REV,    32'sd0, 6'd0, ST_EMPTY, 32'sd0, 6'd0, 6'd0);
    plan_typed(ACT_INSERT, 32'sd5, 6'd0, ST_BADPOS, 32'sd5, 6'd0, 6'd0);
    plan_typed(ACT_INSERT, 32'sd7, 6'd2, ST_BADPOS, 32'sd7, 6'd2, 6'd0);
    plan_typed(ACT_INSERT, 32'sh8000_0000, 6'd1, ST_OK, 32'sh8000_0000, 6'd1, 6'd1);
    plan_typed(ACT_INSERT, 32'sh7fff_ffff, 6'd2, ST_OK, 32'sh7fff_ffff, 6'd2, 6'd2);
    plan_typed(ACT_INSERT, -32'sd1, 6'd1, ST_OK, -32'sd1, 6'd1, 6'd3);
    plan_typed(ACT_INSERT, 32'sd0, 6'd63, ST_BADPOS, 32'sd0, 6'd63, 6'd3);
    plan_open(ACT_SPARE_LO, 32'sd0, 6'd0);
    plan_open(ACT_SPARE_HI, -32'sd1, 6'd63);
    plan_open(ACT_FWD, 32'sd0, 6'd0);
    plan_open(ACT_REV, 32'sd0, 6'd0);
    plan_open(ACT_SEARCH, 32'sh7fff_ffff, 6'd0);
    plan_typed(ACT_SEARCH, 32'sd12345, 6'd0, ST_NOTFOUND, 32'sd12345, 6'd0, 6'd3);
    plan_typed(ACT_DELETE, 32'sd0, 6'd0, ST_BADPOS, 32'sd0, 6'd0, 6'd3);
    plan_typed(ACT_DELETE, 32'sd0, 6'd4, ST_BADPOS, 32'sd0, 6'd4, 6'd3);
    plan_open(ACT_DELETE, 32'sd0, 6'd2);
    plan_open(ACT_INSERT, -32'sd1, 6'd3);
    plan_open(ACT_SEARCH, -32'sd1, 6'd0);
    plan_typed(ACT_DELETE, 32'sd0, 6'd63, ST_BADPOS, 32'sd0, 6'd63, 6'd3);
    plan_typed(ACT_COUNT, 32'sd0, 6'd0, ST_OK, 32'sd0, 6'd0, 6'd3);
    plan_open(ACT_INSERT, 32'sd1, 6'd4);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_command(script[i].cmd, script[i].typed, script[i].want);

    for (int k = 0; k < 260; k++) begin
      if (k == 90 || k == 180) wait_all_results();
      n = list_vals.size();
      if (filling && n == MAX_ENTRIES_DEF && $urandom_range(0, 5) == 0) filling = 1'b0;
      else if (!filling && n == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      c.value    = ($urandom_range(0, 3) == 0) ? word_t'($urandom_range(0, 7)) : word_t'($urandom);
      c.position = POS_W'($urandom_range(0, 63));
      if ($urandom_range(0, 99) < 8) begin
        c.action = ACT_W'($urandom_range(0, 7));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < (filling ? 60 : 15)) begin
          c.action = ACT_INSERT;
          if ($urandom_range(0, 9) != 0) c.position = POS_W'($urandom_range(1, n + 1));
        end else if (roll < (filling ? 70 : 60)) begin
          c.action = ACT_DELETE;
          if (n > 0 && $urandom_range(0, 9) != 0) c.position = POS_W'($urandom_range(1, n));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
              c.action = ACT_SEARCH;
              if (n > 0 && $urandom_range(0, 9) < 6) c.value = list_vals[$urandom_range(0, n - 1)];
            end
            5: c.action = ACT_COUNT;
            6, 7: c.action = ACT_FWD;
            default: c.action = ACT_REV;
          endcase
        end
      end
      send_command(c, 1'b0, '0);
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin : result_side
    out_item_t e;
    out_item_t r;
    int        hold;
    int        n_taken;
    n_taken = 0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 29) == 0) take_calm = !take_calm;
      // long hold so the block backs up and stalls its input
      if (n_taken == 100 || n_taken == 600) hold = HOLD_CYCLES;
      else hold = take_calm ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      r = out_data;
      n_taken++;
      if (pending_results.size() == 0) begin
        report_mismatch("transfer with nothing awaited, value", r.value_res, 0);
      end else begin
        e = pending_results.pop_front();
        if (r.status !== e.status) report_mismatch("status", r.status, e.status);
        if (r.value_res !== e.value_res) report_mismatch("value_res", r.value_res, e.value_res);
        if (r.position_res !== e.position_res) begin
          report_mismatch("position_res", r.position_res, e.position_res);
        end
        if (r.count !== e.count) report_mismatch("count", r.count, e.count);
        if (r.last !== e.last) report_mismatch("last", r.last, e.last);
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ positional_list_engine.f @@
+incdir+rtl/core
rtl/core/plst_pkg.sv
rtl/core/plst_ram.sv
rtl/core/plst_queue.sv
rtl/core/plst_front.sv
rtl/core/plst_back.sv
rtl/core/positional_list_engine.sv
test/testbench.sv
